/* src/dbse_pkg.sv */
// Package for the disk BIOS service engine.
// Holds function codes, result kinds, register indexes and the controller command struct.
// No dependencies; every other file but dbse_ifs imports it.
`default_nettype none

package dbse_pkg;

    // Disk service function numbers (AH).
    localparam logic [7:0] FN_RESET  = 8'h00;
    localparam logic [7:0] FN_STATUS = 8'h01;
    localparam logic [7:0] FN_READ   = 8'h02;
    localparam logic [7:0] FN_WRITE  = 8'h03;
    localparam logic [7:0] FN_VERIFY = 8'h04;
    localparam logic [7:0] FN_PARAMS = 8'h08;
    localparam logic [7:0] FN_TYPE   = 8'h15;

    // Status codes returned in AH.
    localparam logic [7:0] ST_OK      = 8'h00;
    localparam logic [7:0] ST_BAD_CMD = 8'h01;
    localparam logic [7:0] ST_NO_SECT = 8'h04;

    // Result kinds.
    localparam logic [1:0] RK_REPLY    = 2'd0;
    localparam logic [1:0] RK_TRANSFER = 2'd1;
    localparam logic [1:0] RK_NONE     = 2'd2;

    // Input kinds.
    localparam logic KIND_CALL    = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_CYLINDERS = 2'd0;
    localparam logic [1:0] REG_HEADS     = 2'd1;
    localparam logic [1:0] REG_SPT       = 2'd2;

    localparam int CFG_ADDR_W   = 4;
    localparam int SECTOR_SHIFT = 9;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;   // capture a new input word
        logic mul;     // first multiply step
        logic commit;  // finish the item and load the result register
    } dbse_cmd_t;

endpackage

`default_nettype wire

/* src/dbse_ifs.sv */
// Channel interfaces of the disk BIOS service engine: call input and result output.
// Each carries valid, ready and the word payload. No dependencies.
`default_nettype none

interface dbse_call_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] reg_ax;
    logic [15:0] reg_bx;
    logic [15:0] reg_cx;
    logic [15:0] reg_dx;
    logic [15:0] reg_es;

    modport source (output valid, kind, reg_ax, reg_bx, reg_cx, reg_dx, reg_es,
                    input ready);
    modport sink (input valid, kind, reg_ax, reg_bx, reg_cx, reg_dx, reg_es,
                  output ready);
endinterface

interface dbse_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [15:0] ax_out;
    logic [15:0] cx_out;
    logic [15:0] dx_out;
    logic        carry_out;
    logic [33:0] disk_offset;
    logic [20:0] mem_address;
    logic        to_disk;
    logic        last_transfer;

    modport source (output valid, result_kind, ax_out, cx_out, dx_out, carry_out,
                    disk_offset, mem_address, to_disk, last_transfer,
                    input ready);
    modport sink (input valid, result_kind, ax_out, cx_out, dx_out, carry_out,
                  disk_offset, mem_address, to_disk, last_transfer,
                  output ready);
endinterface

`default_nettype wire

/* src/dbse_cfg.sv */
// Geometry register file of the disk BIOS service engine behind an APB-style port.
// Depends on dbse_pkg for register indexes and the address width.
`default_nettype none

module dbse_cfg
    import dbse_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    output logic      [10:0]           cylinders,
    output logic      [8:0]            heads,
    output logic      [5:0]            sectors_per_track
);

    logic [10:0] cyl_reg;
    logic [8:0]  heads_reg;
    logic [5:0]  spt_reg;
    logic [1:0]  index;
    logic        wr_en;

    assign pready = 1'b1;
    assign index  = paddr[3:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyl_reg   <= 11'd80;
            heads_reg <= 9'd2;
            spt_reg   <= 6'd18;
        end
        else if (wr_en)
        begin
            case (index)
                REG_CYLINDERS: cyl_reg   <= pwdata[10:0];
                REG_HEADS:     heads_reg <= pwdata[8:0];
                REG_SPT:       spt_reg   <= pwdata[5:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_CYLINDERS: prdata = {21'd0, cyl_reg};
            REG_HEADS:     prdata = {23'd0, heads_reg};
            REG_SPT:       prdata = {26'd0, spt_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign cylinders         = cyl_reg;
    assign heads             = heads_reg;
    assign sectors_per_track = spt_reg;

endmodule

`default_nettype wire

/* src/dbse_ctrl.sv */
// Controller of the disk BIOS service engine: item sequencing and result word valid.
// Depends on dbse_pkg for the command struct.
`default_nettype none

module dbse_ctrl
    import dbse_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output dbse_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;
    logic   in_fire;

    // The result register is free when empty or being taken this cycle.
    assign slot_free  = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == S_IDLE) || ((state_reg == S_FIN) && slot_free);
    assign in_fire    = in_valid && in_ready;

    assign cmd.latch  = in_fire;
    assign cmd.mul    = (state_reg == S_MUL);
    assign cmd.commit = (state_reg == S_FIN) && slot_free;
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_MUL;
            end
            S_MUL:
                state_next = S_FIN;
            S_FIN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = in_valid ? S_MUL : S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* src/dbse_dp.sv */
// Datapath of the disk BIOS service engine: call decode, CHS check, image offset
// multiply in two steps, transfer counters and the result register. Depends on dbse_pkg.
`default_nettype none

module dbse_dp
    import dbse_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dbse_cmd_t   cmd,
    input  wire logic        kind,
    input  wire logic [15:0] reg_ax,
    input  wire logic [15:0] reg_bx,
    input  wire logic [15:0] reg_cx,
    input  wire logic [15:0] reg_dx,
    input  wire logic [15:0] reg_es,
    input  wire logic [10:0] cylinders,
    input  wire logic [8:0]  heads,
    input  wire logic [5:0]  sectors_per_track,
    output logic      [1:0]  result_kind,
    output logic      [15:0] ax_out,
    output logic      [15:0] cx_out,
    output logic      [15:0] dx_out,
    output logic             carry_out,
    output logic      [33:0] disk_offset,
    output logic      [20:0] mem_address,
    output logic             to_disk,
    output logic             last_transfer
);

    // Captured input word.
    logic        kind_reg;
    logic [15:0] ax_reg, bx_reg, cx_reg, dx_reg, es_reg;
    logic [18:0] prod_reg;

    // Engine state.
    logic [7:0]  last_status_reg, last_status_next;
    logic [16:0] bytes_left_reg, bytes_left_next;
    logic [33:0] cur_off_reg, cur_off_next;
    logic [15:0] seg_reg, seg_next;
    logic [15:0] off_reg, off_next;
    logic        dir_reg, dir_next;

    // Result register.
    logic [1:0]  rk_reg, rk_next;
    logic [15:0] rax_reg, rax_next;
    logic [15:0] rcx_reg, rcx_next;
    logic [15:0] rdx_reg, rdx_next;
    logic        rcarry_reg, rcarry_next;
    logic [33:0] rdoff_reg, rdoff_next;
    logic [20:0] rmaddr_reg, rmaddr_next;
    logic        rto_reg, rto_next;
    logic        rlast_reg, rlast_next;

    logic [7:0]  fn;
    logic [9:0]  cyl;
    logic [7:0]  hd;
    logic [5:0]  sec;
    logic        bad_addr;
    logic [18:0] prod_next;
    logic [24:0] lin;
    logic [33:0] image_off;
    logic [10:0] maxc_full;
    logic [9:0]  maxc;
    logic [8:0]  maxh_full;
    logic [7:0]  maxh;
    logic [7:0]  st;
    logic [15:0] ncx, ndx;
    logic        arm;

    assign fn  = ax_reg[15:8];
    assign cyl = {cx_reg[7:6], cx_reg[15:8]};
    assign hd  = dx_reg[15:8];
    assign sec = cx_reg[5:0];

    assign bad_addr = (sec == 6'd0) || (sec > sectors_per_track)
                   || ({1'b0, hd} >= heads) || ({1'b0, cyl} >= cylinders);

    // Step one: cylinder times heads plus head. Step two: times sectors per track.
    assign prod_next = 19'(cyl) * 19'(heads) + 19'(hd);
    assign lin       = 25'(prod_reg) * 25'(sectors_per_track) + 25'(sec) - 25'd1;
    assign image_off = {lin, {SECTOR_SHIFT{1'b0}}};

    // Highest indices for the parameters call, saturated to the CHS field widths.
    assign maxc_full = (cylinders == 11'd0) ? 11'd0 : cylinders - 11'd1;
    assign maxc      = maxc_full[10] ? 10'd1023 : maxc_full[9:0];
    assign maxh_full = (heads == 9'd0) ? 9'd0 : heads - 9'd1;
    assign maxh      = maxh_full[8] ? 8'd255 : maxh_full[7:0];

    always_comb
    begin
        st  = ST_BAD_CMD;
        ncx = cx_reg;
        ndx = dx_reg;
        arm = 1'b0;
        case (fn)
            FN_RESET, FN_VERIFY:
                st = ST_OK;
            FN_STATUS:
                st = last_status_reg;
            FN_READ, FN_WRITE:
            begin
                st  = bad_addr ? ST_NO_SECT : ST_OK;
                arm = !bad_addr;
            end
            FN_PARAMS:
            begin
                if (dx_reg[7:0] == 8'd0)
                begin
                    st  = ST_OK;
                    ncx = {maxc[7:0], maxc[9:8], sectors_per_track};
                    ndx = {maxh, 8'd1};
                end
            end
            default:
                st = ST_BAD_CMD;
        endcase
    end

    always_comb
    begin
        last_status_next = last_status_reg;
        bytes_left_next  = bytes_left_reg;
        cur_off_next     = cur_off_reg;
        seg_next         = seg_reg;
        off_next         = off_reg;
        dir_next         = dir_reg;
        rk_next          = RK_REPLY;
        rax_next         = 16'd0;
        rcx_next         = 16'd0;
        rdx_next         = 16'd0;
        rcarry_next      = 1'b0;
        rdoff_next       = 34'd0;
        rmaddr_next      = 21'd0;
        rto_next         = 1'b0;
        rlast_next       = 1'b0;
        if (kind_reg == KIND_ADVANCE)
        begin
            if (bytes_left_reg == 17'd0)
            begin
                rk_next = RK_NONE;
            end
            else
            begin
                rk_next         = RK_TRANSFER;
                rdoff_next      = cur_off_reg;
                rmaddr_next     = {1'b0, seg_reg, 4'd0} + {5'd0, off_reg};
                rto_next        = dir_reg;
                rlast_next      = (bytes_left_reg == 17'd1);
                cur_off_next    = cur_off_reg + 34'd1;
                off_next        = off_reg + 16'd1;
                bytes_left_next = bytes_left_reg - 17'd1;
            end
        end
        else
        begin
            rax_next         = {st, ax_reg[7:0]};
            rcx_next         = ncx;
            rdx_next         = ndx;
            rcarry_next      = (st != ST_OK);
            last_status_next = st;
            if (arm)
            begin
                cur_off_next    = image_off;
                bytes_left_next = {ax_reg[7:0], {SECTOR_SHIFT{1'b0}}};
                seg_next        = es_reg;
                off_next        = bx_reg;
                dir_next        = (fn == FN_WRITE);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg <= kind;
            ax_reg   <= reg_ax;
            bx_reg   <= reg_bx;
            cx_reg   <= reg_cx;
            dx_reg   <= reg_dx;
            es_reg   <= reg_es;
        end
        if (cmd.mul)
            prod_reg <= prod_next;
        if (cmd.commit)
        begin
            rk_reg     <= rk_next;
            rax_reg    <= rax_next;
            rcx_reg    <= rcx_next;
            rdx_reg    <= rdx_next;
            rcarry_reg <= rcarry_next;
            rdoff_reg  <= rdoff_next;
            rmaddr_reg <= rmaddr_next;
            rto_reg    <= rto_next;
            rlast_reg  <= rlast_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_status_reg <= 8'd0;
            bytes_left_reg  <= 17'd0;
            cur_off_reg     <= 34'd0;
            seg_reg         <= 16'd0;
            off_reg         <= 16'd0;
            dir_reg         <= 1'b0;
        end
        else if (cmd.commit)
        begin
            last_status_reg <= last_status_next;
            bytes_left_reg  <= bytes_left_next;
            cur_off_reg     <= cur_off_next;
            seg_reg         <= seg_next;
            off_reg         <= off_next;
            dir_reg         <= dir_next;
        end
    end

    assign result_kind   = rk_reg;
    assign ax_out        = rax_reg;
    assign cx_out        = rcx_reg;
    assign dx_out        = rdx_reg;
    assign carry_out     = rcarry_reg;
    assign disk_offset   = rdoff_reg;
    assign mem_address   = rmaddr_reg;
    assign to_disk       = rto_reg;
    assign last_transfer = rlast_reg;

endmodule

`default_nettype wire

/* src/disk_bios_service_engine_top.sv */
// Top level of the disk BIOS service engine: geometry registers, controller, datapath.
// Depends on dbse_pkg, dbse_ifs, dbse_cfg, dbse_ctrl and dbse_dp.
//
//   Channel | Direction | Handshake            | Word
//   call    | in        | valid/ready          | kind, reg_ax..reg_es
//   result  | out       | valid/ready          | result_kind .. last_transfer
//   apb     | in        | psel/penable, pready | paddr, pwdata, prdata
//
// Every word runs through two steps: a multiply of cylinder by heads, then a multiply
// by sectors per track that also commits state and loads the result register.
// A new word is taken in the commit cycle, as the last one finishes. A result not
// yet taken holds the commit cycle until taken.
// Reset clears the control state and engine state; geometry resets to 80/2/18.
`default_nettype none

module disk_bios_service_engine_top
    import dbse_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    dbse_call_if.sink                  call,
    dbse_result_if.source              result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready
);

    logic [10:0] cylinders;
    logic [8:0]  heads;
    logic [5:0]  sectors_per_track;
    dbse_cmd_t   cmd;

    dbse_cfg u_cfg (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .cylinders         (cylinders),
        .heads             (heads),
        .sectors_per_track (sectors_per_track)
    );

    dbse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (call.valid),
        .in_ready  (call.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    dbse_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .kind              (call.kind),
        .reg_ax            (call.reg_ax),
        .reg_bx            (call.reg_bx),
        .reg_cx            (call.reg_cx),
        .reg_dx            (call.reg_dx),
        .reg_es            (call.reg_es),
        .cylinders         (cylinders),
        .heads             (heads),
        .sectors_per_track (sectors_per_track),
        .result_kind       (result.result_kind),
        .ax_out            (result.ax_out),
        .cx_out            (result.cx_out),
        .dx_out            (result.dx_out),
        .carry_out         (result.carry_out),
        .disk_offset       (result.disk_offset),
        .mem_address       (result.mem_address),
        .to_disk           (result.to_disk),
        .last_transfer     (result.last_transfer)
    );

endmodule

`default_nettype wire

/* tb/dbse_reply_checker.sv */
`timescale 1ns / 1ps
// Reply checker for the disk BIOS service engine: snoops the call, result and APB ports,
// predicts every reply or transfer word and compares it field by field in order.
// Depends on dbse_pkg and the channel interfaces in dbse_ifs.
module dbse_reply_checker
    import dbse_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    dbse_call_if                  call_mon,
    dbse_result_if                result_mon,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output int                    mismatch_count,
    output int                    outstanding
);

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] ax_out;
        logic [15:0] cx_out;
        logic [15:0] dx_out;
        logic        carry_out;
        logic [33:0] disk_offset;
        logic [20:0] mem_address;
        logic        to_disk;
        logic        last_transfer;
    } disk_reply_t;

    disk_reply_t pending_replies[$];
    int          fails = 0;

    // Geometry as last written over APB.
    logic [10:0] geo_cyl;
    logic [8:0]  geo_heads;
    logic [5:0]  geo_spt;

    // Engine state mirrored from the transfer side.
    logic [7:0]  last_status;
    logic [16:0] bytes_left;
    logic [33:0] cur_disk_off;
    logic [15:0] buf_seg;
    logic [15:0] buf_off;
    logic        dir_write;

    // Checks the CHS address and, if it is good, arms a transfer; returns the status for AH.
    function automatic logic [7:0] arm_transfer(input logic [15:0] ax, bx, cx, dx, es,
                                                input logic write_dir);
        logic [9:0]      cyl;
        logic [7:0]      hd;
        logic [5:0]      sec;
        longint unsigned lba;
        cyl = {cx[7:6], cx[15:8]};
        hd  = dx[15:8];
        sec = cx[5:0];
        if (sec == 6'd0 || sec > geo_spt || {1'b0, hd} >= geo_heads || {1'b0, cyl} >= geo_cyl)
            return ST_NO_SECT;
        lba = cyl;
        lba = (lba * geo_heads + hd) * geo_spt + sec - 1;
        cur_disk_off = 34'(lba << SECTOR_SHIFT);
        bytes_left   = {ax[7:0], 9'd0};
        buf_seg      = es;
        buf_off      = bx;
        dir_write    = write_dir;
        return ST_OK;
    endfunction

    function automatic disk_reply_t predict_service(input logic kind,
                                                    input logic [15:0] ax, bx, cx, dx, es);
        disk_reply_t r;
        logic [7:0]  st;
        logic [15:0] ncx;
        logic [15:0] ndx;
        logic [10:0] maxc;
        logic [8:0]  maxh;
        r = '0;
        if (kind == KIND_ADVANCE) begin
            if (bytes_left == 17'd0) begin
                r.result_kind = RK_NONE;
            end
            else begin
                r.result_kind   = RK_TRANSFER;
                r.disk_offset   = cur_disk_off;
                r.mem_address   = {1'b0, buf_seg, 4'h0} + {5'd0, buf_off};
                r.to_disk       = dir_write;
                r.last_transfer = (bytes_left == 17'd1);
                cur_disk_off    = cur_disk_off + 34'd1;
                buf_off         = buf_off + 16'd1;
                bytes_left      = bytes_left - 17'd1;
            end
            return r;
        end
        ncx = cx;
        ndx = dx;
        case (ax[15:8])
            FN_RESET, FN_VERIFY: st = ST_OK;
            FN_STATUS:           st = last_status;
            FN_READ:             st = arm_transfer(ax, bx, cx, dx, es, 1'b0);
            FN_WRITE:            st = arm_transfer(ax, bx, cx, dx, es, 1'b1);
            FN_PARAMS: begin
                if (dx[7:0] != 8'd0) begin
                    st = ST_BAD_CMD;
                end
                else begin
                    // Highest indices, clipped to what CHS registers can carry.
                    maxc = (geo_cyl == 11'd0) ? 11'd0 : geo_cyl - 11'd1;
                    if (maxc > 11'd1023)
                        maxc = 11'd1023;
                    maxh = (geo_heads == 9'd0) ? 9'd0 : geo_heads - 9'd1;
                    if (maxh > 9'd255)
                        maxh = 9'd255;
                    ncx = {maxc[7:0], maxc[9:8], geo_spt};
                    ndx = {maxh[7:0], 8'h01};
                    st  = ST_OK;
                end
            end
            FN_TYPE: st = ST_BAD_CMD;
            default: st = ST_BAD_CMD;
        endcase
        last_status   = st;
        r.result_kind = RK_REPLY;
        r.ax_out      = {st, ax[7:0]};
        r.cx_out      = ncx;
        r.dx_out      = ndx;
        r.carry_out   = (st != ST_OK);
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [33:0] want,
                                          input logic [33:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        disk_reply_t want;
        disk_reply_t got;
        if (!rst_n) begin
            geo_cyl      = 11'd80;
            geo_heads    = 9'd2;
            geo_spt      = 6'd18;
            last_status  = ST_OK;
            bytes_left   = '0;
            cur_disk_off = '0;
            buf_seg      = '0;
            buf_off      = '0;
            dir_write    = 1'b0;
            pending_replies.delete();
        end
        else begin
            // Results first: a word taken at this edge cannot answer a call taken here.
            if (result_mon.valid && result_mon.ready) begin
                got.result_kind   = result_mon.result_kind;
                got.ax_out        = result_mon.ax_out;
                got.cx_out        = result_mon.cx_out;
                got.dx_out        = result_mon.dx_out;
                got.carry_out     = result_mon.carry_out;
                got.disk_offset   = result_mon.disk_offset;
                got.mem_address   = result_mon.mem_address;
                got.to_disk       = result_mon.to_disk;
                got.last_transfer = result_mon.last_transfer;
                if (pending_replies.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result word: expected none, actual 0x%0h",
                             $time, got);
                end
                else begin
                    want = pending_replies.pop_front();
                    compare_field("result_kind", 34'(want.result_kind), 34'(got.result_kind));
                    compare_field("ax_out", 34'(want.ax_out), 34'(got.ax_out));
                    compare_field("cx_out", 34'(want.cx_out), 34'(got.cx_out));
                    compare_field("dx_out", 34'(want.dx_out), 34'(got.dx_out));
                    compare_field("carry_out", 34'(want.carry_out), 34'(got.carry_out));
                    compare_field("disk_offset", want.disk_offset, got.disk_offset);
                    compare_field("mem_address", 34'(want.mem_address), 34'(got.mem_address));
                    compare_field("to_disk", 34'(want.to_disk), 34'(got.to_disk));
                    compare_field("last_transfer", 34'(want.last_transfer),
                                  34'(got.last_transfer));
                end
            end
            if (call_mon.valid && call_mon.ready)
                pending_replies.push_back(predict_service(call_mon.kind, call_mon.reg_ax,
                                                          call_mon.reg_bx, call_mon.reg_cx,
                                                          call_mon.reg_dx, call_mon.reg_es));
            if (psel && penable && pwrite && pready) begin
                case (paddr[CFG_ADDR_W-1:2])
                    REG_CYLINDERS: geo_cyl   = pwdata[10:0];
                    REG_HEADS:     geo_heads = pwdata[8:0];
                    REG_SPT:       geo_spt   = pwdata[5:0];
                    default: ;
                endcase
            end
        end
        mismatch_count <= fails;
        outstanding    <= pending_replies.size();
    end

endmodule

/* tb/tb_disk_bios_service_engine_top.sv */
`timescale 1ns / 1ps
// Testbench top for the disk BIOS service engine: clock, reset, call stimulus,
// result back-pressure, geometry writes over APB and the verdict.
// Depends on dbse_pkg, dbse_ifs, the engine RTL and dbse_reply_checker.
module tb_disk_bios_service_engine_top;
    import dbse_pkg::*;

    localparam int STALL_MAX      = 13;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int mismatch_count;
    int outstanding;
    int quiet_cycles = 0;
    int n_calls      = 0;
    int n_advances   = 0;
    int n_settings   = 1;
    bit tx_idle_en   = 1'b1;
    bit rx_idle_en   = 1'b1;

    // Geometry as the stimulus side knows it, used to aim at valid addresses.
    int geo_cyl   = 80;
    int geo_heads = 2;
    int geo_spt   = 18;

    dbse_call_if   call_ch();
    dbse_result_if result_ch();

    disk_bios_service_engine_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .call    (call_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dbse_reply_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .call_mon       (call_ch),
        .result_mon     (result_ch),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    task automatic send_word(input logic kind, input logic [15:0] ax, bx, cx, dx, es);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, STALL_MAX) : 0;
        if (gap != 0) begin
            call_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        call_ch.valid  <= 1'b1;
        call_ch.kind   <= kind;
        call_ch.reg_ax <= ax;
        call_ch.reg_bx <= bx;
        call_ch.reg_cx <= cx;
        call_ch.reg_dx <= dx;
        call_ch.reg_es <= es;
        do @(posedge clk); while (!call_ch.ready);
        if (kind == KIND_CALL)
            n_calls++;
        else
            n_advances++;
    endtask

    task automatic call_fn(input logic [7:0] fn, al, input logic [15:0] bx, cx, dx, es);
        send_word(KIND_CALL, {fn, al}, bx, cx, dx, es);
    endtask

    // Register fields are don't-care on an advance, so they carry noise.
    task automatic advance_n(input int n);
        repeat (n)
            send_word(KIND_ADVANCE, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom));
    endtask

    task automatic wait_for_replies(input int settle);
        call_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_geometry(input int cyl, input int hds, input int spt);
        wait_for_replies(4);
        apb_write(REG_CYLINDERS, 32'(cyl));
        apb_write(REG_HEADS, 32'(hds));
        apb_write(REG_SPT, 32'(spt));
        geo_cyl   = cyl;
        geo_heads = hds;
        geo_spt   = spt;
        n_settings++;
    endtask

    task automatic other_call();
        logic [7:0]  fn;
        logic [15:0] dx;
        case ($urandom_range(0, 5))
            0:       fn = FN_RESET;
            1:       fn = FN_STATUS;
            2:       fn = FN_VERIFY;
            3:       fn = FN_PARAMS;
            4:       fn = FN_TYPE;
            default: fn = 8'($urandom);
        endcase
        dx = 16'($urandom);
        if (fn == FN_PARAMS && $urandom_range(0, 2) != 0)
            dx[7:0] = 8'h00;
        call_fn(fn, 8'($urandom), 16'($urandom), 16'($urandom), dx, 16'($urandom));
    endtask

    task automatic random_sequence();
        int          pick;
        int          n;
        int          top_c;
        int          top_h;
        int          top_s;
        int          cyl;
        int          hd;
        int          sec;
        logic [9:0]  cyl_b;
        logic [7:0]  al;
        logic [15:0] bx;
        if ($urandom_range(0, 24) == 0) begin
            tx_idle_en = ($urandom_range(0, 2) != 0);
            rx_idle_en = ($urandom_range(0, 2) != 0);
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            // Well-formed read or write on an address inside the geometry, then a burst.
            top_c = (geo_cyl > 1024 ? 1024 : geo_cyl) - 1;
            top_h = (geo_heads > 256 ? 256 : geo_heads) - 1;
            top_s = geo_spt > 63 ? 63 : geo_spt;
            if (top_c < 0)
                top_c = 0;
            if (top_h < 0)
                top_h = 0;
            if (top_s < 1)
                top_s = 1;
            cyl   = ($urandom_range(0, 3) == 0) ? top_c : $urandom_range(0, top_c);
            hd    = ($urandom_range(0, 3) == 0) ? top_h : $urandom_range(0, top_h);
            sec   = ($urandom_range(0, 3) == 0) ? top_s : $urandom_range(1, top_s);
            cyl_b = 10'(cyl);
            al    = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 3));
            bx    = ($urandom_range(0, 3) == 0) ? 16'hffff - 16'($urandom_range(0, 15))
                                                : 16'($urandom);
            call_fn($urandom_range(0, 1) ? FN_WRITE : FN_READ, al, bx,
                    {cyl_b[7:0], cyl_b[9:8], 6'(sec)}, {8'(hd), 8'($urandom)},
                    16'($urandom));
            n = $urandom_range(1, 24);
            repeat (n) begin
                if ($urandom_range(0, 19) == 0)
                    other_call();
                advance_n(1);
            end
        end
        else if (pick < 70) begin
            // Unconstrained read or write, mostly off the disk.
            call_fn($urandom_range(0, 1) ? FN_WRITE : FN_READ, 8'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom));
            advance_n($urandom_range(0, 3));
        end
        else if (pick < 90) begin
            other_call();
        end
        else if (pick < 97) begin
            send_word(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom));
        end
        else begin
            // Hold off until the engine has answered everything.
            wait_for_replies(0);
        end
    endtask

    // Result side: per word a random stall with ready low, then ready until taken.
    initial begin
        int stall;
        forever begin
            stall = rx_idle_en ? $urandom_range(0, STALL_MAX) : 0;
            if (stall != 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    always @(posedge clk) begin
        if ((call_ch.valid && call_ch.ready) || (result_ch.valid && result_ch.ready)
            || (psel && penable)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int ph;
        int target;
        rst_n          <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        call_ch.valid  <= 1'b0;
        call_ch.kind   <= KIND_CALL;
        call_ch.reg_ax <= '0;
        call_ch.reg_bx <= '0;
        call_ch.reg_cx <= '0;
        call_ch.reg_dx <= '0;
        call_ch.reg_es <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed calls on the reset geometry of 80 cylinders, 2 heads, 18 sectors.
        call_fn(FN_STATUS, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        call_fn(8'hff, 8'hff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        call_fn(FN_STATUS, 8'h5a, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        call_fn(FN_TYPE, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        call_fn(FN_RESET, 8'hff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        call_fn(FN_VERIFY, 8'h01, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        call_fn(FN_PARAMS, 8'h00, 16'h0000, 16'h1234, 16'hab00, 16'h0000);
        call_fn(FN_PARAMS, 8'h00, 16'h0000, 16'h1234, 16'h0080, 16'h0000);
        advance_n(1);
        // Sector zero, sector past the track, head past the last, cylinder past the last.
        call_fn(FN_READ, 8'h01, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        call_fn(FN_READ, 8'h01, 16'h0000, 16'h0013, 16'h0000, 16'h0000);
        call_fn(FN_WRITE, 8'h01, 16'h0000, 16'h0001, 16'h0200, 16'h0000);
        call_fn(FN_READ, 8'h01, 16'h0000, 16'h5001, 16'h0000, 16'h0000);
        call_fn(FN_STATUS, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // A zero sector count arms a transfer of no bytes.
        call_fn(FN_READ, 8'h00, 16'h0000, 16'h0001, 16'h0000, 16'h0000);
        advance_n(1);
        // Last sector of the disk, buffer offset wrapping inside the top segment.
        call_fn(FN_WRITE, 8'h01, 16'hfffe, 16'h4f12, 16'h0100, 16'hffff);
        advance_n(3);
        call_fn(FN_READ, 8'h02, 16'h0000, 16'h0001, 16'h0000, 16'h0000);
        advance_n(1);
        // A bad address leaves the pending transfer where it was.
        call_fn(FN_READ, 8'h01, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        advance_n(1);

        // One full sector streamed to its last byte and one word past it.
        call_fn(FN_WRITE, 8'h01, 16'($urandom), 16'h0001, 16'h0000, 16'($urandom));
        advance_n(513);

        target = n_calls + n_advances;
        for (ph = 0; ph < PHASES; ph++) begin
            if (ph == 1)
                set_geometry(1, 1, 1);
            else if (ph == 2)
                set_geometry(1024, 256, 63);
            else if (ph == 3)
                set_geometry(2047, 511, 63);
            else if (ph == 4)
                set_geometry(0, 0, 0);
            else if (ph > 4)
                set_geometry($urandom_range(1, 1024), $urandom_range(1, 256),
                             $urandom_range(1, 63));
            target += (ph == 4) ? 40 : 110;
            while (n_calls + n_advances < target)
                random_sequence();
        end

        wait_for_replies(8);
        $display("Sent %0d service calls and %0d advance words across %0d disk geometries.",
                 n_calls, n_advances, n_settings);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
